/* sv/lfu_pkg.sv */
// Shared types and constants of the LFU cache with LRU tie-break.
package lfu_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CAP_W    = 5;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 16;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0]  key;
        logic [WORD_W-1:0]  value;
        logic [COUNT_W-1:0] use_count;
        logic [IDX_W-1:0]   age_rank;
    } lfu_entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        lfu_entry_t       wdata;
        logic [IDX_W-1:0] raddr;
    } lfu_ram_req_t;

    typedef struct packed {
        logic              hit;
        logic [WORD_W-1:0] read_value;
        logic              evicted;
    } lfu_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } lfu_state_t;

endpackage

/* sv/lfu_entry_ram.sv */
// Entry store: one write port, one registered read port.
module lfu_entry_ram
    import lfu_pkg::*;
(
    input  logic         clk,
    input  lfu_ram_req_t req,
    output lfu_entry_t   rdata
);

    lfu_entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

/* sv/lfu_ctrl.sv */
// Request sequencer: scan pass for match, free slot and victim, then, when the table changes, a rank update pass.
module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CAP_W-1:0]  cap,
    input  logic              cfg_clear,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_kind,
    input  logic [WORD_W-1:0] in_key,
    input  logic [WORD_W-1:0] in_value,
    output logic              res_valid,
    input  logic              res_ready,
    output lfu_result_t       res,
    output lfu_ram_req_t      ram_req,
    input  lfu_entry_t        ram_rdata
);

    lfu_state_t state_reg, state_next;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]    n_reg, n_next;

    logic              kind_reg, kind_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] val_reg, val_next;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  hit_rank_reg, hit_rank_next;
    logic [WORD_W-1:0] hit_value_reg, hit_value_next;
    logic              free_found_reg, free_found_next;
    logic [IDX_W-1:0]  free_slot_reg, free_slot_next;
    logic              vic_vld_reg, vic_vld_next;
    logic [IDX_W-1:0]  vic_idx_reg, vic_idx_next;
    logic [COUNT_W-1:0] vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]  vic_rank_reg, vic_rank_next;

    logic              tgt_new_reg, tgt_new_next;
    logic              rank_all_reg, rank_all_next;
    logic [IDX_W-1:0]  thr_reg, thr_next;

    lfu_result_t result_reg, result_next;

    logic [CNT_W-1:0] cap_n;
    logic             issue;
    lfu_entry_t       upd;

    always_comb
    begin
        if (int'(cap) > CAPACITY)
        begin
            cap_n = CNT_W'(CAPACITY);
        end
        else
        begin
            cap_n = CNT_W'(cap);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            chk_vld_reg <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        rd_cnt_reg     <= rd_cnt_next;
        n_reg          <= n_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        found_reg      <= found_next;
        slot_reg       <= slot_next;
        hit_rank_reg   <= hit_rank_next;
        hit_value_reg  <= hit_value_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        vic_vld_reg    <= vic_vld_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        tgt_new_reg    <= tgt_new_next;
        rank_all_reg   <= rank_all_next;
        thr_reg        <= thr_next;
        result_reg     <= result_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        chk_idx_next    = rd_cnt_reg[IDX_W-1:0];
        rd_cnt_next     = rd_cnt_reg;
        n_next          = n_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        hit_rank_next   = hit_rank_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        vic_vld_next    = vic_vld_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        tgt_new_next    = tgt_new_reg;
        rank_all_next   = rank_all_reg;
        thr_next        = thr_reg;
        result_next     = result_reg;

        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = result_reg;

        issue = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) &&
                (rd_cnt_reg != n_reg);
        chk_vld_next = issue;
        if (issue)
        begin
            rd_cnt_next = rd_cnt_reg + CNT_W'(1);
        end

        ram_req.raddr = rd_cnt_reg[IDX_W-1:0];
        ram_req.we    = 1'b0;
        ram_req.waddr = chk_idx_reg;
        upd           = ram_rdata;
        ram_req.wdata = upd;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    kind_next       = in_kind;
                    key_next        = in_key;
                    val_next        = in_value;
                    n_next          = cap_n;
                    rd_cnt_next     = '0;
                    chk_vld_next    = 1'b0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    vic_vld_next    = 1'b0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (valid_reg[chk_idx_reg])
                    begin
                        if (!found_reg && ram_rdata.key == key_reg)
                        begin
                            found_next     = 1'b1;
                            slot_next      = chk_idx_reg;
                            hit_rank_next  = ram_rdata.age_rank;
                            hit_value_next = ram_rdata.value;
                        end
                        // lowest count wins, older entry on a tie
                        if (!vic_vld_reg || ram_rdata.use_count < vic_cnt_reg ||
                            (ram_rdata.use_count == vic_cnt_reg &&
                             ram_rdata.age_rank > vic_rank_reg))
                        begin
                            vic_vld_next  = 1'b1;
                            vic_idx_next  = chk_idx_reg;
                            vic_cnt_next  = ram_rdata.use_count;
                            vic_rank_next = ram_rdata.age_rank;
                        end
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = chk_idx_reg;
                    end
                end
                if (!chk_vld_reg && rd_cnt_reg == n_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                result_next.hit        = found_reg;
                result_next.read_value = '0;
                result_next.evicted    = 1'b0;
                rd_cnt_next            = '0;
                chk_vld_next           = 1'b0;
                if (found_reg)
                begin
                    if (kind_reg == KIND_GET)
                    begin
                        result_next.read_value = hit_value_reg;
                    end
                    slot_next     = slot_reg;
                    thr_next      = hit_rank_reg;
                    rank_all_next = 1'b0;
                    tgt_new_next  = 1'b0;
                    state_next    = ST_UPDATE;
                end
                else if (kind_reg == KIND_PUT && n_reg != '0)
                begin
                    tgt_new_next = 1'b1;
                    if (free_found_reg)
                    begin
                        slot_next     = free_slot_reg;
                        rank_all_next = 1'b1;
                    end
                    else
                    begin
                        // ranks above the victim drop then rise: only younger ones move
                        slot_next           = vic_idx_reg;
                        thr_next            = vic_rank_reg;
                        rank_all_next       = 1'b0;
                        result_next.evicted = 1'b1;
                    end
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_UPDATE:
            begin
                if (chk_vld_reg)
                begin
                    if (chk_idx_reg == slot_reg)
                    begin
                        upd.key      = key_reg;
                        upd.age_rank = '0;
                        if (kind_reg == KIND_PUT)
                        begin
                            upd.value = val_reg;
                        end
                        if (tgt_new_reg)
                        begin
                            upd.use_count = COUNT_W'(1);
                        end
                        else if (ram_rdata.use_count != COUNT_MAX)
                        begin
                            upd.use_count = ram_rdata.use_count + COUNT_W'(1);
                        end
                        ram_req.we = 1'b1;
                        valid_next[chk_idx_reg] = 1'b1;
                    end
                    else if (valid_reg[chk_idx_reg] &&
                             (rank_all_reg || ram_rdata.age_rank < thr_reg))
                    begin
                        upd.age_rank = ram_rdata.age_rank + IDX_W'(1);
                        ram_req.we   = 1'b1;
                    end
                end
                ram_req.wdata = upd;
                if (!chk_vld_reg && rd_cnt_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            valid_next = '0;
        end
    end

endmodule

/* sv/lfu_cache_with_lru_tiebreak.sv */
// Top level of the LFU cache with LRU tie-break: stream ports, capacity register, output register.
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  tuser: kind; tdata: key, put_value
//  m_*       out        m_tvalid/m_tready  tdata: hit, read_value, evicted
//  cfg_*     in         cfg_wr_en          cfg_wr_data: capacity
//
// A request takes one scan pass of n reads, n the active capacity, over the
// entry RAM (one read per cycle) and, when the table changes, one read-modify-write
// pass for the recency ranks; the single RAM read port sets this pace.
// Reset empties the table and sets the capacity to 16; no clearing pass is needed.
// A waiting result sits in the output register while the next request is taken.
module lfu_cache_with_lru_tiebreak
    import lfu_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key [31:0], put_value [63:32]
    input  logic                   s_tuser,   // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // hit [0], read_value [32:1], evicted [33]
    input  logic                   cfg_wr_en,
    input  logic [CAP_W-1:0]       cfg_wr_data
);

    logic [CAP_W-1:0] cap_reg;
    logic             out_vld_reg;
    lfu_result_t      out_data_reg;

    logic         res_valid;
    logic         res_ready;
    lfu_result_t  res;
    lfu_ram_req_t ram_req;
    lfu_entry_t   ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    assign res_ready = !out_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_data_reg.evicted, out_data_reg.read_value, out_data_reg.hit};

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .cfg_clear (cfg_wr_en),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    lfu_entry_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule
